// ----- rtl/core/bgmh_pkg.sv -----
// Package for the battery gauge: sizes, reset values, codes and shared types.
// Used by the front, queue, back, top level and checker. No dependencies.
`default_nettype none

package bgmh_pkg;

   localparam int SAMPLES    = 10;
   localparam int ADC_BITS   = 12;
   localparam int CNT_W      = $clog2(SAMPLES);
   localparam int MID        = SAMPLES / 2;
   localparam int SUM_W      = ADC_BITS + 2;
   localparam int FULL_W     = ADC_BITS + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = FULL_W;
   localparam int MARGIN_W   = 5;
   localparam int PCT_W      = 7;
   localparam int LVL_W      = 3;
   localparam int LVL_TH_W   = 8;
   localparam int MV_W       = 13;
   localparam int MV_SCALE   = 4200;
   localparam int MVP_W      = ADC_BITS + MV_W;
   localparam int NUM_W      = ADC_BITS + PCT_W;
   localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
   localparam int RECIP_K    = SUM_W + 2;
   localparam int RECIP3     = (2 ** RECIP_K + 2) / 3;
   localparam int AVP_W      = SUM_W + RECIP_K;
   localparam int QDEPTH     = 2;
   localparam int QPTR_W     = $clog2(QDEPTH);

   localparam int PCT_FULL    = 100;
   localparam int LVL_STEP    = 20;
   localparam int LVL_QUARTER = 25;

   localparam logic [LVL_W-1:0] LVL_MIN = LVL_W'(1);
   localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(5);

   localparam logic [ADC_BITS-1:0] EMPTY_RST  = ADC_BITS'(2900);
   localparam logic [FULL_W-1:0]   FULL_RST   = FULL_W'(4096);
   localparam logic [ADC_BITS-1:0] THRESH_RST = ADC_BITS'(300);
   localparam logic [MARGIN_W-1:0] RAISE_RST  = MARGIN_W'(10);
   localparam logic [MARGIN_W-1:0] DROP_RST   = MARGIN_W'(5);

   localparam logic FUNC_MEAS = 1'b0;
   localparam logic FUNC_PRES = 1'b1;
   localparam logic KIND_MEAS = 1'b0;
   localparam logic KIND_PRES = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EMPTY  = 3'd0,
      CSR_FULL   = 3'd1,
      CSR_THRESH = 3'd2,
      CSR_RAISE  = 3'd3,
      CSR_DROP   = 3'd4
   } csr_idx_type;

   typedef enum logic {
      F_TAKE,
      F_SUM
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_AVG,
      B_SCALE,
      B_DIV,
      B_PCT,
      B_EMIT
   } back_state_type;

   typedef struct packed {
      logic [ADC_BITS-1:0] empty;
      logic [FULL_W-1:0]   full;
      logic [ADC_BITS-1:0] thresh;
      logic [MARGIN_W-1:0] raise;
      logic [MARGIN_W-1:0] drop;
   } cfg_type;

   typedef struct packed {
      logic             func;
      logic [SUM_W-1:0] data;
      logic             pin;
   } qent_type;

   typedef struct packed {
      logic                kind;
      logic [ADC_BITS-1:0] avg;
      logic [MV_W-1:0]     mv;
      logic [PCT_W-1:0]    pct;
      logic [LVL_W-1:0]    lvl;
      logic                lvl_chg;
      logic                batt;
      logic                chg;
      logic                batt_chg;
      logic                chg_chg;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/battery_gauge_median_hysteresis_top.sv -----
// Battery gauge with median averaging and bar-level hysteresis.
// Request channel (req_*): one word per ADC reading. func 0 adds a sample to
//   the current batch; func 1 is a presence and charger check.
// Response channel (rsp_*): one word per completed batch (kind 0) and one per
//   presence check (kind 1). A func 0 word that does not close a batch gives
//   no response.
// Register port (csr_*): always ready; index 0 empty code, 1 full code,
//   2 presence threshold, 3 raise margin, 4 drop margin; other indexes ignored.
// Flow: each sample word is inserted in sorted order on arrival; the word that
//   closes a batch then holds off new words while F_SUM sums the middle samples.
//   The back end steps a batch through B_AVG, B_SCALE, the one-bit-per-cycle
//   percent divider in B_DIV and B_PCT, and a presence check straight to B_EMIT.
//   A two-entry queue sits between front and back end.
// Path: a presence check passes through the queue and B_EMIT to rsp_valid, a batch
//   result through F_SUM, the queue and the back-end states.
// Stall: while rsp_ready is low the response holds; the back end waits, the
//   queue fills and then req_ready drops.
// Reset: synchronous; clears the batch, level, flags and registers to defaults.
`default_nettype none

module battery_gauge_median_hysteresis_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_func,
   input  wire logic [bgmh_pkg::ADC_BITS-1:0]   req_adc_sample,
   input  wire logic                            req_charger_pin,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_kind,
   output logic [bgmh_pkg::ADC_BITS-1:0]        rsp_average_code,
   output logic [bgmh_pkg::MV_W-1:0]            rsp_voltage_mv,
   output logic [bgmh_pkg::PCT_W-1:0]           rsp_percent,
   output logic [bgmh_pkg::LVL_W-1:0]           rsp_bar_level,
   output logic                                 rsp_level_changed,
   output logic                                 rsp_battery_present,
   output logic                                 rsp_charger_present,
   output logic                                 rsp_battery_changed,
   output logic                                 rsp_charger_changed,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [bgmh_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bgmh_pkg::CSR_DATA_W-1:0] csr_data
);
   import bgmh_pkg::*;

   cfg_type  cfg_ff;
   logic     q_full;
   logic     q_push;
   qent_type q_push_data;
   logic     q_pop;
   logic     q_valid;
   qent_type q_pop_data;
   rsp_type  rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{empty: EMPTY_RST, full: FULL_RST, thresh: THRESH_RST,
                     raise: RAISE_RST, drop: DROP_RST};
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_EMPTY:  cfg_ff.empty  <= csr_data[ADC_BITS-1:0];
            CSR_FULL:   cfg_ff.full   <= csr_data[FULL_W-1:0];
            CSR_THRESH: cfg_ff.thresh <= csr_data[ADC_BITS-1:0];
            CSR_RAISE:  cfg_ff.raise  <= csr_data[MARGIN_W-1:0];
            CSR_DROP:   cfg_ff.drop   <= csr_data[MARGIN_W-1:0];
            default:    cfg_ff        <= cfg_ff;
         endcase
      end
   end

   bgmh_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_adc_sample  (req_adc_sample),
      .req_charger_pin (req_charger_pin),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_push_data     (q_push_data)
   );

   bgmh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_pop_data)
   );

   bgmh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_data    (q_pop_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_kind            = rsp.kind;
   assign rsp_average_code    = rsp.avg;
   assign rsp_voltage_mv      = rsp.mv;
   assign rsp_percent         = rsp.pct;
   assign rsp_bar_level       = rsp.lvl;
   assign rsp_level_changed   = rsp.lvl_chg;
   assign rsp_battery_present = rsp.batt;
   assign rsp_charger_present = rsp.chg;
   assign rsp_battery_changed = rsp.batt_chg;
   assign rsp_charger_changed = rsp.chg_chg;

endmodule

`default_nettype wire

// ----- rtl/core/bgmh_front.sv -----
// Front end: accepts request words, keeps the batch sorted by insertion and
// forwards batch sums and presence checks to the queue. Depends on bgmh_pkg.
`default_nettype none

module bgmh_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_func,
   input  wire logic [bgmh_pkg::ADC_BITS-1:0] req_adc_sample,
   input  wire logic                         req_charger_pin,
   input  wire logic                         q_full,
   output logic                              q_push,
   output bgmh_pkg::qent_type                q_push_data
);
   import bgmh_pkg::*;

   front_state_type     state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADC_BITS-1:0] sorted_ff [SAMPLES];
   logic [ADC_BITS-1:0] sorted_in [SAMPLES];
   logic [SAMPLES-1:0]  lt;
   logic                take;
   logic                take_meas;
   logic                last_sample;
   logic [SUM_W-1:0]    mid_sum;

   assign take        = req_valid && req_ready;
   assign take_meas   = take && (req_func == FUNC_MEAS);
   assign last_sample = (count_ff == CNT_W'(SAMPLES - 1));

   always_comb begin
      for (int i = 0; i < SAMPLES; i++) begin
         lt[i] = (CNT_W'(i) < count_ff) && (sorted_ff[i] <= req_adc_sample);
      end
      sorted_in[0] = lt[0] ? sorted_ff[0] : req_adc_sample;
      for (int i = 1; i < SAMPLES; i++) begin
         if (lt[i]) begin
            sorted_in[i] = sorted_ff[i];
         end else if (lt[i-1]) begin
            sorted_in[i] = req_adc_sample;
         end else begin
            sorted_in[i] = sorted_ff[i-1];
         end
      end
   end

   assign mid_sum = SUM_W'(sorted_ff[MID-1]) + SUM_W'(sorted_ff[MID])
                  + SUM_W'(sorted_ff[MID+1]);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_TAKE: if (take_meas && last_sample) state_in = F_SUM;
         F_SUM:  if (!q_full) state_in = F_TAKE;
         default: state_in = F_TAKE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      q_push      = 1'b0;
      q_push_data = '{func: FUNC_PRES, data: SUM_W'(req_adc_sample), pin: req_charger_pin};
      unique case (state_ff)
         F_TAKE: begin
            req_ready = !q_full;
            q_push    = take && (req_func == FUNC_PRES);
         end
         F_SUM: begin
            q_push      = !q_full;
            q_push_data = '{func: FUNC_MEAS, data: mid_sum, pin: 1'b0};
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (take_meas) begin
         count_in = last_sample ? '0 : count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_TAKE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_meas) begin
         sorted_ff <= sorted_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/bgmh_queue.sv -----
// Short FIFO between the gauge front end and back end.
// Entry type and depth come from bgmh_pkg.
`default_nettype none

module bgmh_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  bgmh_pkg::qent_type push_data,
   output logic               full,
   input  wire logic          pop,
   output logic               valid,
   output bgmh_pkg::qent_type pop_data
);
   import bgmh_pkg::*;

   qent_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;

   assign full     = (count_ff == (QPTR_W+1)'(QDEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      priority if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/bgmh_back.sv -----
// Back end: averages the middle samples, scales to millivolts, divides for
// percent, runs the bar-level hysteresis, updates the presence flags and holds the
// response register. Depends on bgmh_pkg.
`default_nettype none

module bgmh_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  bgmh_pkg::cfg_type  cfg,
   input  wire logic          q_valid,
   input  bgmh_pkg::qent_type q_data,
   output logic               q_pop,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output bgmh_pkg::rsp_type  rsp
);
   import bgmh_pkg::*;

   back_state_type       state_ff, state_in;
   qent_type             ent_ff;
   logic [ADC_BITS-1:0]  avg_ff;
   logic [MV_W-1:0]      mv_ff;
   logic [PCT_W-1:0]     pct_ff, pct_in;
   logic [NUM_W-1:0]     div_num_ff;
   logic [FULL_W-1:0]    div_den_ff;
   logic [FULL_W-1:0]    div_rem_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic                 num_neg_ff;
   logic                 den_neg_ff;
   logic                 den_zero_ff;

   logic [LVL_W-1:0]     level_ff, level_in;
   logic                 level_valid_ff, level_valid_in;
   logic [PCT_W-1:0]     last_pct_ff, last_pct_in;
   logic                 batt_ff, batt_in;
   logic                 chg_ff, chg_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;

   logic                 emit;
   logic [AVP_W-1:0]     avg_prod;
   logic [MVP_W-1:0]     mv_prod;
   logic [ADC_BITS-1:0]  diff;
   logic [FULL_W-1:0]    empty_ext;
   logic                 den_neg;
   logic [FULL_W-1:0]    den_mag;
   logic [FULL_W:0]      trial;
   logic                 trial_ge;
   logic [LVL_TH_W-1:0]  up_th;
   logic [LVL_TH_W-1:0]  dn_th;
   logic [LVL_TH_W-1:0]  pct_ext;
   logic [LVL_TH_W-1:0]  pct_plus;
   logic [LVL_W-1:0]     hyst_level;
   logic                 new_batt;

   function automatic logic [LVL_W-1:0] first_level(input logic [PCT_W-1:0] p);
      logic [LVL_W-1:0] l;
      priority if (p >= PCT_W'(4 * LVL_QUARTER)) l = LVL_W'(5);
      else if (p >= PCT_W'(3 * LVL_QUARTER))     l = LVL_W'(4);
      else if (p >= PCT_W'(2 * LVL_QUARTER))     l = LVL_W'(3);
      else if (p >= PCT_W'(LVL_QUARTER))         l = LVL_W'(2);
      else                                       l = LVL_W'(1);
      return l;
   endfunction

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:  if (q_valid) state_in = (q_data.func == FUNC_PRES) ? B_EMIT : B_AVG;
         B_AVG:   state_in = B_SCALE;
         B_SCALE: state_in = B_DIV;
         B_DIV:   if (div_cnt_ff == DIV_CNT_W'(1)) state_in = B_PCT;
         B_PCT:   state_in = B_EMIT;
         B_EMIT:  if (!rsp_valid_ff || rsp_ready) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      q_pop = 1'b0;
      emit  = 1'b0;
      unique case (state_ff)
         B_IDLE:  q_pop = q_valid;
         B_EMIT:  emit  = !rsp_valid_ff || rsp_ready;
         default: q_pop = 1'b0;
      endcase
   end

   assign avg_prod  = AVP_W'(ent_ff.data) * AVP_W'(RECIP3);
   assign mv_prod   = MVP_W'(avg_ff) * MVP_W'(MV_SCALE);
   assign diff      = (avg_ff >= cfg.empty) ? avg_ff - cfg.empty : cfg.empty - avg_ff;
   assign empty_ext = {1'b0, cfg.empty};
   assign den_neg   = (cfg.full < empty_ext);
   assign den_mag   = den_neg ? empty_ext - cfg.full : cfg.full - empty_ext;
   assign trial     = {div_rem_ff, div_num_ff[NUM_W-1]};
   assign trial_ge  = (trial >= {1'b0, div_den_ff});

   always_comb begin
      priority if (den_zero_ff) begin
         pct_in = num_neg_ff ? '0 : PCT_W'(PCT_FULL);
      end else if (num_neg_ff != den_neg_ff) begin
         pct_in = '0;
      end else if (div_num_ff > NUM_W'(PCT_FULL)) begin
         pct_in = PCT_W'(PCT_FULL);
      end else begin
         pct_in = div_num_ff[PCT_W-1:0];
      end
   end

   assign pct_ext  = LVL_TH_W'(pct_ff);
   assign up_th    = LVL_TH_W'(level_ff) * LVL_TH_W'(LVL_STEP) + LVL_TH_W'(cfg.raise);
   assign dn_th    = (LVL_TH_W'(level_ff) - LVL_TH_W'(1)) * LVL_TH_W'(LVL_STEP);
   assign pct_plus = pct_ext + LVL_TH_W'(cfg.drop);
   assign new_batt = (ent_ff.data[ADC_BITS-1:0] >= cfg.thresh);

   always_comb begin
      priority if (pct_ext >= up_th) begin
         hyst_level = (level_ff >= LVL_MAX) ? LVL_MAX : level_ff + LVL_W'(1);
      end else if (pct_plus <= dn_th) begin
         hyst_level = (level_ff <= LVL_MIN) ? LVL_MIN : level_ff - LVL_W'(1);
      end else begin
         hyst_level = level_ff;
      end
   end

   always_comb begin
      level_in       = level_ff;
      level_valid_in = level_valid_ff;
      last_pct_in    = last_pct_ff;
      batt_in        = batt_ff;
      chg_in         = chg_ff;
      if (ent_ff.func == FUNC_PRES) begin
         batt_in = new_batt;
         chg_in  = ent_ff.pin;
      end else begin
         last_pct_in = pct_ff;
         if (batt_ff) begin
            level_valid_in = 1'b1;
            level_in       = level_valid_ff ? hyst_level : first_level(pct_ff);
         end
      end
      rsp_in = '{kind:     ent_ff.func,
                 avg:      (ent_ff.func == FUNC_PRES) ? '0 : avg_ff,
                 mv:       (ent_ff.func == FUNC_PRES) ? '0 : mv_ff,
                 pct:      last_pct_in,
                 lvl:      level_in,
                 lvl_chg:  (level_in != level_ff),
                 batt:     batt_in,
                 chg:      chg_in,
                 batt_chg: (batt_in != batt_ff),
                 chg_chg:  (chg_in != chg_ff)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= B_IDLE;
         level_ff       <= LVL_MIN;
         level_valid_ff <= 1'b0;
         last_pct_ff    <= '0;
         batt_ff        <= 1'b0;
         chg_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         div_cnt_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            level_ff       <= level_in;
            level_valid_ff <= level_valid_in;
            last_pct_ff    <= last_pct_in;
            batt_ff        <= batt_in;
            chg_ff         <= chg_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff   <= 1'b0;
         end
         if (state_ff == B_SCALE) begin
            div_cnt_ff <= DIV_CNT_W'(NUM_W);
         end else if (state_ff == B_DIV) begin
            div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         ent_ff <= q_data;
      end
      if (state_ff == B_AVG) begin
         avg_ff <= avg_prod[RECIP_K +: ADC_BITS];
      end
      if (state_ff == B_SCALE) begin
         mv_ff       <= mv_prod[ADC_BITS +: MV_W];
         div_num_ff  <= NUM_W'(diff) * NUM_W'(PCT_FULL);
         div_den_ff  <= den_mag;
         div_rem_ff  <= '0;
         num_neg_ff  <= (avg_ff < cfg.empty);
         den_neg_ff  <= den_neg;
         den_zero_ff <= (den_mag == '0);
      end
      if (state_ff == B_DIV) begin
         div_num_ff <= {div_num_ff[NUM_W-2:0], trial_ge};
         div_rem_ff <= trial_ge ? FULL_W'(trial - {1'b0, div_den_ff}) : trial[FULL_W-1:0];
      end
      if (state_ff == B_PCT) begin
         pct_ff <= pct_in;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/core/bgmh_checker.sv -----
// Port-level checks for the battery gauge top level, and the bind that
// attaches them. Depends on bgmh_pkg and battery_gauge_median_hysteresis_top.
`default_nettype none

module bgmh_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic                            rsp_kind,
   input wire logic [bgmh_pkg::ADC_BITS-1:0]   rsp_average_code,
   input wire logic [bgmh_pkg::MV_W-1:0]       rsp_voltage_mv,
   input wire logic [bgmh_pkg::PCT_W-1:0]      rsp_percent,
   input wire logic [bgmh_pkg::LVL_W-1:0]      rsp_bar_level,
   input wire logic                            rsp_level_changed,
   input wire logic                            rsp_battery_changed,
   input wire logic                            rsp_charger_changed
);
   import bgmh_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_bar_level) && $stable(rsp_percent))
      else $error("response word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_meas_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_MEAS) |-> !rsp_battery_changed && !rsp_charger_changed)
      else $error("batch result reports a flag change");

   a_pres_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_PRES) |->
         (rsp_average_code == '0) && (rsp_voltage_mv == '0) && !rsp_level_changed)
      else $error("presence result carries measurement fields");

   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bar_level >= LVL_MIN) && (rsp_bar_level <= LVL_MAX)
         && (rsp_percent <= PCT_W'(PCT_FULL)))
      else $error("bar level or percent out of range");

endmodule

bind battery_gauge_median_hysteresis_top bgmh_checker u_bgmh_checker (.*);

`default_nettype wire

// ----- test/tb_battery_gauge_median_hysteresis_top.sv -----
`timescale 1ns / 100ps
// Testbench for battery_gauge_median_hysteresis_top: drives reading words and register
// writes through valid/ready, predicts every response word and checks it field by field.
// Depends on bgmh_pkg and the battery_gauge_median_hysteresis_top RTL.

module tb_battery_gauge_median_hysteresis_top;
   import bgmh_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT   = 3000;
   localparam int PHASE_WORDS   = 210;
   localparam int MAX_REPORTS   = 100;
   localparam int CODE_MAX      = 2 ** ADC_BITS - 1;

   class gauge_scoreboard;
      int empty_code;
      int full_code;
      int thresh_code;
      int raise_pct;
      int drop_pct;
      int batch[SAMPLES];
      int batch_fill;
      int level;
      int level_set;
      int last_pct;
      int batt_flag;
      int chg_flag;
      int errors;
      rsp_type due_reports[$];

      function new();
         empty_code  = EMPTY_RST;
         full_code   = FULL_RST;
         thresh_code = THRESH_RST;
         raise_pct   = RAISE_RST;
         drop_pct    = DROP_RST;
         batch_fill  = 0;
         level       = LVL_MIN;
         level_set   = 0;
         last_pct    = 0;
         batt_flag   = 0;
         chg_flag    = 0;
         errors      = 0;
      endfunction

      function void write_reg(csr_idx_type idx, int value);
         case (idx)
            CSR_EMPTY:  empty_code  = value;
            CSR_FULL:   full_code   = value;
            CSR_THRESH: thresh_code = value;
            CSR_RAISE:  raise_pct   = value;
            CSR_DROP:   drop_pct    = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return due_reports.size();
      endfunction

      function void take_reading(logic func, logic [ADC_BITS-1:0] sample, logic pin);
         int sorted[SAMPLES];
         int i;
         int j;
         int v;
         int avg;
         int pct;
         int lv;
         int old_level;
         longint num;
         longint den;
         rsp_type r;
         r = '0;
         if (func == FUNC_MEAS) begin
            batch[batch_fill] = sample;
            batch_fill++;
            if (batch_fill < SAMPLES) return;
            batch_fill = 0;
            for (i = 0; i < SAMPLES; i++) begin
               v = batch[i];
               j = i;
               while (j > 0 && sorted[j-1] > v) begin
                  sorted[j] = sorted[j-1];
                  j--;
               end
               sorted[j] = v;
            end
            avg = (sorted[MID-1] + sorted[MID] + sorted[MID+1]) / 3;
            num = (longint'(avg) - empty_code) * PCT_FULL;
            den = longint'(full_code) - empty_code;
            if (den == 0) begin
               pct = (avg >= empty_code) ? PCT_FULL : 0;
            end else begin
               num = num / den;
               pct = (num < 0) ? 0 : (num > PCT_FULL) ? PCT_FULL : int'(num);
            end
            last_pct  = pct;
            old_level = level;
            if (batt_flag != 0) begin
               if (level_set == 0) begin
                  level     = pct / LVL_QUARTER + int'(LVL_MIN);
                  level_set = 1;
               end else begin
                  lv = level;
                  if (pct >= lv * LVL_STEP + raise_pct) lv++;
                  else if (pct <= (lv - 1) * LVL_STEP - drop_pct) lv--;
                  if (lv < int'(LVL_MIN)) lv = LVL_MIN;
                  if (lv > int'(LVL_MAX)) lv = LVL_MAX;
                  level = lv;
               end
            end
            r.kind    = KIND_MEAS;
            r.avg     = ADC_BITS'(avg);
            r.mv      = MV_W'((avg * MV_SCALE) >> ADC_BITS);
            r.pct     = PCT_W'(pct);
            r.lvl     = LVL_W'(level);
            r.lvl_chg = (level != old_level);
            r.batt    = batt_flag[0];
            r.chg     = chg_flag[0];
         end else begin
            v = (int'(sample) >= thresh_code) ? 1 : 0;
            r.kind     = KIND_PRES;
            r.batt_chg = (v != batt_flag);
            r.chg_chg  = (int'(pin) != chg_flag);
            batt_flag  = v;
            chg_flag   = pin;
            r.pct      = PCT_W'(last_pct);
            r.lvl      = LVL_W'(level);
            r.batt     = batt_flag[0];
            r.chg      = pin;
         end
         due_reports.push_back(r);
      endfunction

      function void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
         if (got_v !== want_v) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
         end
      endfunction

      function void check_report(rsp_type got);
         rsp_type want;
         if (due_reports.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: response word with none expected, expected nothing got %h",
                        $time, got);
            return;
         end
         want = due_reports.pop_front();
         check_field("kind", want.kind, got.kind);
         check_field("average_code", want.avg, got.avg);
         check_field("voltage_mv", want.mv, got.mv);
         check_field("percent", want.pct, got.pct);
         check_field("bar_level", want.lvl, got.lvl);
         check_field("level_changed", want.lvl_chg, got.lvl_chg);
         check_field("battery_present", want.batt, got.batt);
         check_field("charger_present", want.chg, got.chg);
         check_field("battery_changed", want.batt_chg, got.batt_chg);
         check_field("charger_changed", want.chg_chg, got.chg_chg);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_func;
   logic [ADC_BITS-1:0] req_adc_sample;
   logic req_charger_pin;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_kind;
   logic [ADC_BITS-1:0] rsp_average_code;
   logic [MV_W-1:0] rsp_voltage_mv;
   logic [PCT_W-1:0] rsp_percent;
   logic [LVL_W-1:0] rsp_bar_level;
   logic rsp_level_changed;
   logic rsp_battery_present;
   logic rsp_charger_present;
   logic rsp_battery_changed;
   logic rsp_charger_changed;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int send_idle_pct;
   int recv_stall_pct;
   int idle_cycles;
   gauge_scoreboard gauge;

   battery_gauge_median_hysteresis_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_adc_sample      (req_adc_sample),
      .req_charger_pin     (req_charger_pin),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_average_code    (rsp_average_code),
      .rsp_voltage_mv      (rsp_voltage_mv),
      .rsp_percent         (rsp_percent),
      .rsp_bar_level       (rsp_bar_level),
      .rsp_level_changed   (rsp_level_changed),
      .rsp_battery_present (rsp_battery_present),
      .rsp_charger_present (rsp_charger_present),
      .rsp_battery_changed (rsp_battery_changed),
      .rsp_charger_changed (rsp_charger_changed),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         gauge.check_report(rsp_type'({rsp_kind, rsp_average_code, rsp_voltage_mv,
                                       rsp_percent, rsp_bar_level, rsp_level_changed,
                                       rsp_battery_present, rsp_charger_present,
                                       rsp_battery_changed, rsp_charger_changed}));
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_word(logic func, int sample, logic pin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_adc_sample  <= ADC_BITS'(sample);
      req_charger_pin <= pin;
      do @(posedge clock); while (!req_ready);
      gauge.take_reading(func, ADC_BITS'(sample), pin);
      @(negedge clock);
   endtask

   task automatic set_reg(csr_idx_type idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      gauge.write_reg(idx, value);
      @(negedge clock);
   endtask

   // hold until every response word is in, then let the back end settle
   task automatic drain();
      while (gauge.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(int e, int f, int t, int r, int d);
      int span;
      int lo;
      int hi;
      int center;
      int jitter;
      int sample;
      int roll;
      int in_batch;
      set_reg(CSR_EMPTY, e);
      set_reg(CSR_FULL, f);
      set_reg(CSR_THRESH, t);
      set_reg(CSR_RAISE, r);
      set_reg(CSR_DROP, d);
      csr_valid <= 1'b0;
      span = (f > e) ? f - e : e - f;
      if (span < 64) span = 64;
      lo = ((f < e) ? f : e) - span / 8;
      hi = ((f > e) ? f : e) + span / 8;
      if (lo < 0) lo = 0;
      if (hi > CODE_MAX) hi = CODE_MAX;
      center   = int'($urandom_range(hi, lo));
      jitter   = span / 40 + 2;
      in_batch = 0;
      repeat (PHASE_WORDS) begin
         roll = int'($urandom_range(99));
         if (roll < 12) begin
            if (roll < 2) sample = t;
            else if (roll < 5 && t > 0) sample = int'($urandom_range(t - 1, 0));
            else sample = int'($urandom_range(CODE_MAX, t));
            send_word(FUNC_PRES, sample, 1'($urandom_range(1)));
         end else begin
            if (roll < 17) sample = int'($urandom_range(CODE_MAX));
            else sample = center + int'($urandom_range(2 * jitter)) - jitter;
            if (sample < 0) sample = 0;
            if (sample > CODE_MAX) sample = CODE_MAX;
            send_word(FUNC_MEAS, sample, 1'($urandom_range(1)));
            in_batch++;
            if (in_batch == SAMPLES) begin
               in_batch = 0;
               // drift the batch level so the bar walks up and down
               if ($urandom_range(1)) center = center + int'($urandom_range(span / 6 + 1));
               else center = center - int'($urandom_range(span / 6 + 1));
               if (center < lo) center = lo;
               if (center > hi) center = hi;
            end
         end
      end
      req_valid <= 1'b0;
      drain();
   endtask

   initial begin
      int i;
      int sample;
      gauge           = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = FUNC_MEAS;
      req_adc_sample  = '0;
      req_charger_pin = 1'b0;
      rsp_ready       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = CSR_EMPTY;
      csr_data        = '0;
      idle_cycles     = 0;
      send_idle_pct   = 30;
      recv_stall_pct  = 79;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // battery absent: batch result keeps the level
      send_word(FUNC_PRES, 0, 1'b0);
      for (i = 0; i < SAMPLES; i++) begin
         case (i)
            0: sample = 0;
            1: sample = CODE_MAX;
            2: sample = 'h555;
            3: sample = 'hAAA;
            default: sample = 3400 + 10 * i;
         endcase
         send_word(FUNC_MEAS, sample, i[0]);
      end
      // battery at threshold, then first level-setting batch
      send_word(FUNC_PRES, THRESH_RST, 1'b1);
      for (i = 0; i < SAMPLES; i++)
         send_word(FUNC_MEAS, 3990 + i, 1'b0);
      send_word(FUNC_PRES, THRESH_RST - 1, 1'b1);
      send_word(FUNC_PRES, CODE_MAX, 1'b0);
      req_valid <= 1'b0;
      drain();

      run_phase(EMPTY_RST, FULL_RST, THRESH_RST, RAISE_RST, DROP_RST);
      run_phase(0, CODE_MAX + 1, 0, 0, 0);
      run_phase(CODE_MAX, 1, CODE_MAX, 20, 20);
      send_idle_pct  = 79;
      recv_stall_pct = 30;
      run_phase(2048, 2048, 1000, 10, 10);
      run_phase(3500, 1000, 2000, 5, 15);
      run_phase(1000, 3000, 500, 20, 0);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_phase($urandom_range(CODE_MAX), $urandom_range(CODE_MAX + 1, 1),
                $urandom_range(CODE_MAX), $urandom_range(20), $urandom_range(20));
      run_phase($urandom_range(CODE_MAX), $urandom_range(CODE_MAX + 1, 1),
                $urandom_range(CODE_MAX), $urandom_range(20), $urandom_range(20));

      if (gauge.errors == 0 && gauge.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
